// ===== rtl/i2da_pkg.sv =====
// ---------------------------------------------------------------------------
// i2da_pkg: shared types and constants for the decimal ASCII converter
// Word formats, character codes and the command and status groups that run
// between the controller and the datapath.
// ---------------------------------------------------------------------------
package i2da_pkg;

	// Width of the input value field and digit count of the BCD accumulator.
	localparam int IN_BITS        = 64;
	localparam int BCD_DIGITS     = 20;
	localparam int IDX_W          = $clog2(BCD_DIGITS);
	localparam int LEN_W          = $clog2(BCD_DIGITS + 2);

	// Defaults for the top-level parameters.
	localparam int DEF_VALUE_BITS = 64;
	localparam int DEF_MAX_CHARS  = 20;

	// ASCII codes.
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;

	// Interpretation of the input value.
	localparam logic OP_SIGNED   = 1'b0;
	localparam logic OP_UNSIGNED = 1'b1;

	typedef struct packed {
		logic               op;
		logic [IN_BITS-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last;
	} out_word_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic shift;
		logic scan;
		logic emit;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic can_push;
		logic last_char;
	} dp_stat_t;

endpackage

// ===== rtl/int64_to_decimal_ascii.sv =====
// ---------------------------------------------------------------------------
// int64_to_decimal_ascii: binary to decimal ASCII text converter
// Turns one signed or unsigned integer word into its decimal text, one
// character per output word, most significant character first.
// ---------------------------------------------------------------------------
// Each accepted input word carries a value and an op bit: op = 0 reads the
// low VALUE_BITS bits as two's complement, op = 1 reads them as unsigned.
// The answer is a run of output words, one ASCII character each, with last
// set on the final one. Negative values start with '-', zero gives "0", and
// the most negative signed value is converted exactly. At most MAX_CHARS
// characters are sent; a longer text is cut after MAX_CHARS characters.
// A word is loaded, converted by bit-serial shift-and-add-3 (one bit of the
// magnitude per cycle), its significant digits are counted, and then its
// characters are sent, one per cycle while the output side does not stall.
// The input is ready only between words; the character output sits behind its
// own register, so a waiting character does not hold up the sequencer
// for longer than the receiver takes to accept it.
// ---------------------------------------------------------------------------
module int64_to_decimal_ascii #(
	parameter int VALUE_BITS = i2da_pkg::DEF_VALUE_BITS,
	parameter int MAX_CHARS  = i2da_pkg::DEF_MAX_CHARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  i2da_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output i2da_pkg::out_word_t out_word
);

	// Command and status groups between the sequencer and the datapath.
	i2da_pkg::ctl_cmd_t cmd;
	i2da_pkg::dp_stat_t stat;

	// The sequencer owns the input handshake and the step order.
	i2da_ctrl #(
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the number, the BCD digits and the output register.
	i2da_dp #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_CHARS  (MAX_CHARS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

// ===== rtl/i2da_dp.sv =====
// ---------------------------------------------------------------------------
// i2da_dp: conversion datapath
// Holds the magnitude, a shift-and-add-3 BCD accumulator, the character
// emission pointer and the output register.
// ---------------------------------------------------------------------------
module i2da_dp #(
	parameter int VALUE_BITS = i2da_pkg::DEF_VALUE_BITS,
	parameter int MAX_CHARS  = i2da_pkg::DEF_MAX_CHARS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  i2da_pkg::in_word_t  in_word,
	input  i2da_pkg::ctl_cmd_t  cmd,
	output i2da_pkg::dp_stat_t  stat,
	output logic                out_valid,
	input  logic                out_ready,
	output i2da_pkg::out_word_t out_word
);

	localparam int BD    = i2da_pkg::BCD_DIGITS;
	localparam int IDX_W = i2da_pkg::IDX_W;
	localparam int LEN_W = i2da_pkg::LEN_W;

	logic [VALUE_BITS-1:0] mag_q;
	logic                  neg_q;
	logic [4*BD-1:0]       bcd_q;
	logic [IDX_W-1:0]      idx_q;
	logic [LEN_W-1:0]      rem_q;
	logic                  sign_pend_q;
	logic                  out_valid_q;
	i2da_pkg::out_word_t   out_word_q;

	logic [VALUE_BITS-1:0] raw;
	logic                  neg_in;
	logic [4*BD-1:0]       bcd_adj;
	logic [LEN_W-1:0]      nd;
	logic [LEN_W-1:0]      len_full;
	logic [3:0]            cur_digit;
	i2da_pkg::out_word_t   next_word;

	assign raw    = in_word.value[VALUE_BITS-1:0];
	assign neg_in = (in_word.op == i2da_pkg::OP_SIGNED) && raw[VALUE_BITS-1];

	// Add 3 to every digit of 5 or more before the shift.
	always_comb begin
		for (int i = 0; i < BD; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Number of significant digits, at least one.
	always_comb begin
		nd = LEN_W'(1);
		for (int i = 1; i < BD; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				nd = LEN_W'(i + 1);
			end
		end
	end

	assign len_full  = nd + LEN_W'(neg_q);
	assign cur_digit = bcd_q[4*idx_q +: 4];

	always_comb begin
		next_word.last = (rem_q == LEN_W'(1));
		if (sign_pend_q) begin
			next_word.char_code = i2da_pkg::CHAR_MINUS;
		end else begin
			next_word.char_code = i2da_pkg::CHAR_ZERO + {4'd0, cur_digit};
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= neg_in;
			bcd_q <= '0;
			if (neg_in) begin
				mag_q <= VALUE_BITS'(~raw + 1'b1);
			end else begin
				mag_q <= raw;
			end
		end else if (cmd.shift) begin
			bcd_q <= {bcd_adj[4*BD-2:0], mag_q[VALUE_BITS-1]};
			mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	// Emission pointer and remaining character count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rem_q       <= '0;
			sign_pend_q <= 1'b0;
		end else if (cmd.scan) begin
			idx_q       <= IDX_W'(nd - LEN_W'(1));
			sign_pend_q <= neg_q;
			if (len_full > LEN_W'(MAX_CHARS)) begin
				rem_q <= LEN_W'(MAX_CHARS);
			end else begin
				rem_q <= len_full;
			end
		end else if (cmd.emit) begin
			rem_q <= rem_q - LEN_W'(1);
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	// Output register: a new character enters when it is empty or the old one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_word_q <= next_word;
		end
	end

	assign stat.can_push  = !out_valid_q || out_ready;
	assign stat.last_char = (rem_q == LEN_W'(1));
	assign out_valid      = out_valid_q;
	assign out_word       = out_word_q;

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("character pushed into a full output register");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (rem_q != '0))
		else $error("character emitted beyond the text length");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !sign_pend_q) |-> (cur_digit <= 4'd9))
		else $error("BCD digit out of range");

endmodule

// ===== rtl/i2da_ctrl.sv =====
// ---------------------------------------------------------------------------
// i2da_ctrl: conversion sequencer
// Steps each word through load, bit-serial conversion, digit scan and
// character emission.
// ---------------------------------------------------------------------------
module i2da_ctrl #(
	parameter int VALUE_BITS = i2da_pkg::DEF_VALUE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  i2da_pkg::dp_stat_t stat,
	output i2da_pkg::ctl_cmd_t cmd
);

	localparam int CNT_W = $clog2(VALUE_BITS);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             bits_done;

	assign bits_done = (cnt_q == CNT_W'(VALUE_BITS - 1));

	assign in_ready  = (state_q == S_IDLE);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.shift = (state_q == S_CONV);
	assign cmd.scan  = (state_q == S_SCAN);
	assign cmd.emit  = (state_q == S_EMIT) && stat.can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (cmd.load) begin
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (bits_done) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (cmd.emit && stat.last_char) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_CONV) && (cnt_q == '0))
		else $error("accepted word did not start conversion");

	a_conv_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV && bits_done) |=> (state_q == S_SCAN))
		else $error("conversion did not end after the last bit");

	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && stat.last_char) |=> (state_q == S_IDLE))
		else $error("sequencer kept emitting after the last character");

endmodule

// ===== tb/sv/i2da_sb_pkg.sv =====
// ---------------------------------------------------------------------------
// i2da_sb_pkg: character scoreboard for the decimal ASCII converter bench
// Works out the decimal text of every accepted input word and checks the
// character words that come back against it, oldest first.
// ---------------------------------------------------------------------------
package i2da_sb_pkg;

	import i2da_pkg::*;

	class char_scoreboard;
		out_word_t text_queue[$];
		int        value_bits;
		int        max_chars;
		int        mismatches;
		int        chars_seen;

		function new(int vb, int mc);
			value_bits = vb;
			max_chars  = mc;
			mismatches = 0;
			chars_seen = 0;
		endfunction

		// Appends the expected characters of one input word to the queue.
		function void note_input(in_word_t w);
			logic [63:0] mask;
			logic [63:0] raw;
			logic [63:0] mag;
			logic [63:0] sign_bit;
			logic        negative;
			logic [7:0]  text[$];
			out_word_t   ow;
			int          len;
			mask     = (value_bits >= 64) ? '1 : ((64'd1 << value_bits) - 64'd1);
			raw      = w.value & mask;
			sign_bit = 64'd1 << (value_bits - 1);
			negative = (w.op == OP_SIGNED) && ((raw & sign_bit) != 64'd0);
			mag      = negative ? ((~raw + 64'd1) & mask) : raw;
			// Digits come out least significant first, so build from the front.
			do begin
				text.push_front(CHAR_ZERO + 8'(mag % 64'd10));
				mag = mag / 64'd10;
			end while (mag != 64'd0);
			if (negative)
				text.push_front(CHAR_MINUS);
			len = (text.size() > max_chars) ? max_chars : text.size();
			for (int k = 0; k < len; k++) begin
				ow.char_code = text[k];
				ow.last      = (k == len - 1);
				text_queue.push_back(ow);
			end
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_char(out_word_t got);
			out_word_t want;
			chars_seen++;
			if (text_queue.size() == 0) begin
				report($sformatf("character %0d (0x%02h last %0b) arrived with none expected",
					chars_seen, got.char_code, got.last));
			end else begin
				want = text_queue.pop_front();
				if (got.char_code !== want.char_code)
					report($sformatf("character %0d: char_code expected 0x%02h, got 0x%02h",
						chars_seen, want.char_code, got.char_code));
				if (got.last !== want.last)
					report($sformatf("character %0d: last expected %0b, got %0b",
						chars_seen, want.last, got.last));
			end
		endfunction

		function int pending();
			return text_queue.size();
		endfunction

		function bit clean();
			return (mismatches == 0) && (text_queue.size() == 0);
		endfunction
	endclass

endpackage

// ===== tb/sv/int64_to_decimal_ascii_tb.sv =====
// ---------------------------------------------------------------------------
// int64_to_decimal_ascii_tb: self-checking bench for the decimal converter
// Sends signed and unsigned words, first a directed set of edge values and
// then random ones, and checks every character word against a scoreboard.
// ---------------------------------------------------------------------------
module int64_to_decimal_ascii_tb;

	import i2da_pkg::*;
	import i2da_sb_pkg::*;

	// Longest run of cycles with no handshake on either side before the run
	// is declared hung. It lies well above a word's own conversion time and the
	// long receiver hold-off (HOLD_CYCLES), so this leaves plenty of margin.
	localparam int IDLE_LIMIT   = 5000;
	localparam int RANDOM_WORDS = 430;
	localparam int HOLD_CYCLES  = 600;
	localparam int DRAIN_CYCLES = 120;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_word;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_word;

	char_scoreboard sb;
	int             burst_left;
	int             words_in;
	int             idle_cycles;

	int64_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offers one word and returns once it has been accepted. Words go out in
	// bursts; when a burst runs out, valid drops for a random gap first.
	// Inputs only change on the falling edge, so the block and the monitor
	// see settled values at the rising edge.
	task automatic send_value(input logic op, input logic [63:0] v);
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(30, 1)) @(negedge clk);
			burst_left = $urandom_range(24, 1);
		end else begin
			@(negedge clk);
		end
		in_valid      = 1'b1;
		in_word.op    = op;
		in_word.value = v;
		burst_left--;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Monitor: both handshakes are sampled at the rising edge. The watchdog
	// counts cycles in which neither side moved a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_input(in_word);
				words_in++;
			end
			if (out_valid && out_ready)
				sb.check_char(out_word);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Receiver: stalls on its own pattern, picked per segment. Once a few
	// dozen words have gone in, it holds off for a long stretch so the
	// output register and then the input side back up while the sender keeps
	// offering words.
	initial begin : receiver
		bit held_off;
		int mode;
		out_ready = 1'b0;
		held_off  = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && words_in >= 30) begin
				@(negedge clk);
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held_off = 1'b1;
			end
			mode = $urandom_range(3, 0);
			repeat ($urandom_range(200, 20)) begin
				@(negedge clk);
				case (mode)
					0: out_ready = 1'b1;
					1: out_ready = ($urandom_range(1, 0) == 1);
					2: out_ready = ($urandom_range(9, 0) < 8);
					default: out_ready = ($urandom_range(9, 0) < 2);
				endcase
			end
		end
	end

	initial begin : stimulus
		logic [63:0] v;
		logic [63:0] pw;
		logic        op;
		int          pick;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_word       = '0;
		burst_left    = 0;
		words_in      = 0;
		idle_cycles   = 0;
		sb            = new(DEF_VALUE_BITS, DEF_MAX_CHARS);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: zero both ways, the all-ones and sign-bit patterns
		// under each op, the most negative value, digit count boundaries
		// around powers of ten, and alternating bit patterns.
		send_value(OP_SIGNED,   64'd0);
		send_value(OP_UNSIGNED, 64'd0);
		send_value(OP_SIGNED,   64'd1);
		send_value(OP_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF);
		send_value(OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF);
		send_value(OP_SIGNED,   64'h8000_0000_0000_0000);
		send_value(OP_UNSIGNED, 64'h8000_0000_0000_0000);
		send_value(OP_SIGNED,   64'h7FFF_FFFF_FFFF_FFFF);
		send_value(OP_UNSIGNED, 64'h7FFF_FFFF_FFFF_FFFF);
		send_value(OP_UNSIGNED, 64'd9);
		send_value(OP_UNSIGNED, 64'd10);
		send_value(OP_SIGNED,   64'd99);
		send_value(OP_SIGNED,   64'd100);
		send_value(OP_SIGNED,   64'hFFFF_FFFF_FFFF_FFF6);
		send_value(OP_UNSIGNED, 64'h8AC7_2304_89E8_0000);
		send_value(OP_SIGNED,   64'h8AC7_2304_89E8_0000);
		send_value(OP_UNSIGNED, 64'h8AC7_2304_89E7_FFFF);
		send_value(OP_SIGNED,   64'h0DE0_B6B3_A764_0000);
		send_value(OP_SIGNED,   64'h0DE0_B6B3_A763_FFFF);
		send_value(OP_SIGNED,   64'hF21F_494C_589C_0000);
		send_value(OP_UNSIGNED, 64'hAAAA_AAAA_AAAA_AAAA);
		send_value(OP_SIGNED,   64'h5555_5555_5555_5555);

		// Random part: a mix of full-width values, values of random bit
		// length (so every text length shows up), neighbors of powers of
		// ten, negatives of random bit length, and values near the extremes.
		repeat (RANDOM_WORDS) begin
			op   = 1'($urandom_range(1, 0));
			pick = $urandom_range(9, 0);
			v    = {$urandom, $urandom};
			if (pick >= 4 && pick <= 5) begin
				v = v >> $urandom_range(63, 0);
			end else if (pick >= 6 && pick <= 7) begin
				pw = 64'd1;
				repeat ($urandom_range(19, 0)) pw = pw * 64'd10;
				v = pw + 64'($signed($urandom_range(2, 0)) - 1);
				if ($urandom_range(1, 0) == 1)
					v = ~v + 64'd1;
			end else if (pick == 8) begin
				case ($urandom_range(3, 0))
					0: v = 64'h8000_0000_0000_0000;
					1: v = 64'h7FFF_FFFF_FFFF_FFFF;
					2: v = 64'hFFFF_FFFF_FFFF_FFFF;
					default: v = 64'd0;
				endcase
				v = v ^ 64'($urandom_range(3, 0));
			end else if (pick == 9) begin
				v = ~(v >> $urandom_range(63, 1)) + 64'd1;
			end
			send_value(op, v);
		end

		@(negedge clk);
		in_valid = 1'b0;

		// Wait for the last characters, then give the block time to show
		// any stray word it might still send.
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.clean())
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/i2da_pkg.sv
rtl/i2da_dp.sv
rtl/i2da_ctrl.sv
rtl/int64_to_decimal_ascii.sv
tb/sv/i2da_sb_pkg.sv
tb/sv/int64_to_decimal_ascii_tb.sv
